// File: hw/rtl/twrtc_pkg.sv
// ----------------------------------------------------------------------------
// twrtc_pkg
// Shared types, codes and BCD helpers for the three-wire RTC serial master.
// ----------------------------------------------------------------------------
`default_nettype none

package twrtc_pkg;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic [1:0] KIND_IDLE  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam int unsigned ADDR_BITS = 8;
	localparam int unsigned SEND_BITS = 16;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] reg_address;
		logic [6:0] write_value;
		logic       data_in;
	} in_item_t;

	typedef struct packed {
		logic       enable_pin;
		logic       clock_pin;
		logic       data_out;
		logic       data_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_value;
		logic       rejected;
	} out_item_t;

	// Tens by reciprocal: (v * 205) >> 11 is exact for every 7-bit v (below 128).
	function automatic logic [7:0] to_bcd(input logic [6:0] v);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  units;
		prod  = 15'(v) * 15'd205;
		tens  = prod[14:11];
		units = v - 7'(({3'b000, tens} << 3) + ({3'b000, tens} << 1));
		return {tens, units[3:0]};
	endfunction

	function automatic logic [7:0] from_bcd(input logic [7:0] b);
		logic [7:0] hi;
		hi = {4'b0000, b[7:4]};
		return (hi << 3) + (hi << 1) + {4'b0000, b[3:0]};
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/three_wire_rtc_serial_master.sv
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master
// Bit-level master for a three-wire RTC link: write address plus BCD value,
// or write address+1 and read back one BCD byte as a decimal value.
// ----------------------------------------------------------------------------
// Each accepted word (start write, start read, or tick) produces exactly one
// result word showing the pin levels after it, plus busy, done, the decoded
// read value and a rejected flag for a start issued while busy. A tick moves
// the line by one half bit, so a write takes 32 ticks and a read 31. The block
// accepts one word per cycle while the output is taken: a word is held in the
// input register, then the line state and the result register update together
// once the result register is empty or its word is being taken.
`default_nettype none

module three_wire_rtc_serial_master
	import twrtc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] cmd,
	input  wire logic [7:0] reg_address,
	input  wire logic [6:0] write_value,
	input  wire logic       data_in,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            enable_pin,
	output logic            clock_pin,
	output logic            data_out,
	output logic            data_drive,
	output logic            busy_res,
	output logic            done_res,
	output logic [7:0]      read_value,
	output logic            rejected
);

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_q;
	logic      out_valid_q;
	logic      adv;

	logic        enable_q, clock_q, drive_level_q, drive_en_q, half_q;
	logic [1:0]  kind_q;
	logic [4:0]  count_q;
	logic [15:0] send_q;
	logic [7:0]  recv_q;

	logic        enable_d, clock_d, drive_level_d, drive_en_d, half_d;
	logic [1:0]  kind_d;
	logic [4:0]  count_d;
	logic [15:0] send_d;
	logic [7:0]  recv_d;
	logic        done_d, rej_d;
	logic [7:0]  rdval_d;
	logic        busy, receiving;
	logic [4:0]  count_inc;
	logic [15:0] start_word;
	logic [7:0]  recv_bit;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{cmd: cmd, reg_address: reg_address,
				write_value: write_value, data_in: data_in};
		end
	end

	assign busy      = kind_q != KIND_IDLE;
	assign receiving = (kind_q == KIND_READ) && (count_q >= 5'(ADDR_BITS));
	assign count_inc = count_q + 5'd1;
	assign recv_bit  = 8'(item_s1.data_in) << count_q[2:0];
	assign start_word = (item_s1.cmd == CMD_WRITE)
		? {to_bcd(item_s1.write_value), item_s1.reg_address}
		: {8'h00, item_s1.reg_address + 8'd1};

	always_comb begin
		enable_d      = enable_q;
		clock_d       = clock_q;
		drive_level_d = drive_level_q;
		drive_en_d    = drive_en_q;
		half_d        = half_q;
		kind_d        = kind_q;
		count_d       = count_q;
		send_d        = send_q;
		recv_d        = recv_q;
		done_d        = 1'b0;
		rej_d         = 1'b0;
		rdval_d       = 8'd0;
		if (item_s1.cmd == CMD_WRITE || item_s1.cmd == CMD_READ) begin
			if (busy) begin
				rej_d = 1'b1;
			end else begin
				send_d        = start_word;
				enable_d      = 1'b1;
				clock_d       = 1'b0;
				drive_en_d    = 1'b1;
				drive_level_d = start_word[0];
				count_d       = 5'd0;
				half_d        = 1'b0;
				recv_d        = 8'd0;
				kind_d        = (item_s1.cmd == CMD_WRITE) ? KIND_WRITE : KIND_READ;
			end
		end else if (item_s1.cmd == CMD_TICK && busy) begin
			if (!half_q) begin
				if (receiving) begin
					// sample on the first half; last bit ends the read
					recv_d = recv_q | recv_bit;
					if (count_q[2:0] == 3'd7) begin
						enable_d = 1'b0;
						kind_d   = KIND_IDLE;
						done_d   = 1'b1;
						rdval_d  = from_bcd(recv_q | recv_bit);
					end else begin
						clock_d = 1'b1;
						half_d  = 1'b1;
					end
				end else begin
					clock_d = 1'b1;
					half_d  = 1'b1;
				end
			end else begin
				clock_d = 1'b0;
				half_d  = 1'b0;
				count_d = count_inc;
				if (kind_q == KIND_WRITE) begin
					if (count_inc >= 5'(SEND_BITS)) begin
						enable_d = 1'b0;
						kind_d   = KIND_IDLE;
						done_d   = 1'b1;
					end else begin
						drive_level_d = send_q[count_inc[3:0]];
					end
				end else if (count_inc < 5'(ADDR_BITS)) begin
					drive_level_d = send_q[count_inc[3:0]];
				end else if (count_inc == 5'(ADDR_BITS)) begin
					// release data for the device to answer
					drive_en_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			clock_q       <= 1'b0;
			drive_level_q <= 1'b1;
			drive_en_q    <= 1'b1;
			half_q        <= 1'b0;
			kind_q        <= KIND_IDLE;
			count_q       <= 5'd0;
			send_q        <= 16'd0;
			recv_q        <= 8'd0;
			out_valid_q   <= 1'b0;
		end else begin
			if (adv) begin
				enable_q      <= enable_d;
				clock_q       <= clock_d;
				drive_level_q <= drive_level_d;
				drive_en_q    <= drive_en_d;
				half_q        <= half_d;
				kind_q        <= kind_d;
				count_q       <= count_d;
				send_q        <= send_d;
				recv_q        <= recv_d;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= '{enable_pin: enable_d, clock_pin: clock_d,
				data_out: drive_level_d, data_drive: drive_en_d,
				busy_res: kind_d != KIND_IDLE, done_res: done_d,
				read_value: rdval_d, rejected: rej_d};
		end
	end

	assign out_valid  = out_valid_q;
	assign enable_pin = res_q.enable_pin;
	assign clock_pin  = res_q.clock_pin;
	assign data_out   = res_q.data_out;
	assign data_drive = res_q.data_drive;
	assign busy_res   = res_q.busy_res;
	assign done_res   = res_q.done_res;
	assign read_value = res_q.read_value;
	assign rejected   = res_q.rejected;

endmodule

`default_nettype wire
